@@ hw/rtl/apr_pkg.sv @@
package apr_pkg;

    // Frame geometry.
    localparam int FRAME_W = 1024;
    localparam int FRAME_H = 1024;

    // Field widths.
    localparam int COORD_W = 10;
    localparam int BOX_W   = 11;
    localparam int SHIFT_W = 13;
    localparam int COEF_W  = 24;
    localparam int TRANS_W = 32;

    // Internal datapath widths.
    localparam int UV_W   = 14;
    localparam int PROD_W = COEF_W + UV_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int FRAC_W = 16;
    localparam int RND_W  = ACC_W - FRAC_W;
    localparam int TX_W   = RND_W + 2;

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Register port.
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_COEF_A  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_B  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_C  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_D  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TRANS_E = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TRANS_F = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SHIFT_X = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y = 3'd7;

    typedef struct packed {
        logic signed [COEF_W-1:0]  coef_a;
        logic signed [COEF_W-1:0]  coef_b;
        logic signed [COEF_W-1:0]  coef_c;
        logic signed [COEF_W-1:0]  coef_d;
        logic signed [TRANS_W-1:0] trans_e;
        logic signed [TRANS_W-1:0] trans_f;
        logic signed [SHIFT_W-1:0] shift_x;
        logic signed [SHIFT_W-1:0] shift_y;
    } cfg_t;

    // One classified pixel waiting for the transform.
    typedef struct packed {
        logic signed [UV_W-1:0] u;
        logic signed [UV_W-1:0] v;
        logic                   lit;
        logic                   fs;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ hw/rtl/apr_front.sv @@
module apr_front
    import apr_pkg::*;
(
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [COORD_W-1:0]       pixel_x,
    input  logic [COORD_W-1:0]       pixel_y,
    input  logic                     pixel_lit,
    input  logic                     frame_start,
    input  logic signed [SHIFT_W-1:0] shift_x,
    input  logic signed [SHIFT_W-1:0] shift_y,
    input  q_status_t                q_status,
    output logic                     push,
    output entry_t                   push_entry
);

    logic signed [UV_W-1:0] px_s;
    logic signed [UV_W-1:0] py_s;
    logic signed [UV_W-1:0] sx_s;
    logic signed [UV_W-1:0] sy_s;

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    // Offset the source point and flip the row axis.
    always_comb
    begin
        px_s = $signed({{(UV_W-COORD_W){1'b0}}, pixel_x});
        py_s = $signed({{(UV_W-COORD_W){1'b0}}, pixel_y});
        sx_s = UV_W'(shift_x);
        sy_s = UV_W'(shift_y);
        push_entry.u   = px_s + sx_s;
        push_entry.v   = UV_W'(FRAME_H - 1) - py_s - sy_s;
        push_entry.lit = pixel_lit;
        push_entry.fs  = frame_start;
    end

endmodule

@@ hw/rtl/apr_queue.sv @@
module apr_queue
    import apr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    push_entry,
    input  logic      pop,
    output entry_t    head,
    output q_status_t q_status
);

    entry_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign head           = slot_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ hw/rtl/apr_back.sv @@
module apr_back
    import apr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  q_status_t          q_status,
    input  entry_t             head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               write_en,
    output logic [COORD_W-1:0] dest_x,
    output logic [COORD_W-1:0] dest_y,
    output logic [BOX_W-1:0]   box_x_min,
    output logic [COORD_W-1:0] box_x_max,
    output logic [BOX_W-1:0]   box_y_min,
    output logic [COORD_W-1:0] box_y_max
);

    logic adv;

    // Stage valids.
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    // Flags carried with each pixel.
    logic lit1_reg, lit2_reg, lit3_reg, lit4_reg;
    logic fs1_reg, fs2_reg, fs3_reg, fs4_reg;

    // Stage 1: products.
    logic signed [PROD_W-1:0] au_reg, bv_reg, cu_reg, dv_reg;
    // Stage 2: sums.
    logic signed [ACC_W-1:0] qx_reg, qy_reg;
    logic signed [ACC_W-1:0] au_x, bv_x, cu_x, dv_x, e_x, f_x;
    // Stage 3: rounded integers.
    logic signed [RND_W-1:0] rx_reg, ry_reg, rx_next, ry_next;
    // Stage 4: destination coordinates.
    logic [COORD_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic signed [TX_W-1:0] tx, ty;

    // Output register and box.
    logic               write_en_reg;
    logic [COORD_W-1:0] dest_x_reg, dest_y_reg;
    logic [BOX_W-1:0]   xlo_reg, ylo_reg, xlo_next, ylo_next;
    logic [COORD_W-1:0] xhi_reg, yhi_reg, xhi_next, yhi_next;

    function automatic logic signed [RND_W-1:0] round_even(input logic signed [ACC_W-1:0] q);
        logic [FRAC_W-1:0]       frac;
        logic signed [RND_W-1:0] ip;
        logic                    up;
        frac = q[FRAC_W-1:0];
        ip   = q[ACC_W-1:FRAC_W];
        up   = (frac > {1'b1, {(FRAC_W-1){1'b0}}})
            || ((frac == {1'b1, {(FRAC_W-1){1'b0}}}) && ip[0]);
        return ip + $signed({{(RND_W-1){1'b0}}, up});
    endfunction

    function automatic logic axis_in_range(input logic signed [TX_W-1:0] t, input int lim);
        return !t[TX_W-1] && (t < TX_W'(lim));
    endfunction

    assign adv = !out_valid_reg || !out_stall;
    assign pop = adv && !q_status.empty;

    always_comb
    begin
        au_x = ACC_W'(au_reg);
        bv_x = ACC_W'(bv_reg);
        cu_x = ACC_W'(cu_reg);
        dv_x = ACC_W'(dv_reg);
        e_x  = ACC_W'(cfg.trans_e);
        f_x  = ACC_W'(cfg.trans_f);
        rx_next = round_even(qx_reg);
        ry_next = round_even(qy_reg);
    end

    // Remove the offset and force out-of-range axes and unlit pixels to zero.
    always_comb
    begin
        tx = TX_W'(rx_reg) - TX_W'(cfg.shift_x);
        ty = TX_W'(ry_reg) - TX_W'(cfg.shift_y);
        dx_next = '0;
        dy_next = '0;
        if (axis_in_range(tx, FRAME_W) && lit3_reg)
        begin
            dx_next = tx[COORD_W-1:0];
        end
        if (axis_in_range(ty, FRAME_H) && lit3_reg)
        begin
            dy_next = ty[COORD_W-1:0];
        end
    end

    // Bounding box: a frame start clears it before this pixel is added.
    always_comb
    begin
        if (fs4_reg)
        begin
            xlo_next = BOX_W'(FRAME_W);
            xhi_next = '0;
            ylo_next = BOX_W'(FRAME_H);
            yhi_next = '0;
        end
        else
        begin
            xlo_next = xlo_reg;
            xhi_next = xhi_reg;
            ylo_next = ylo_reg;
            yhi_next = yhi_reg;
        end
        if (lit4_reg && (dx_reg != '0) && (dy_reg != '0))
        begin
            if (xlo_next > {1'b0, dx_reg})
            begin
                xlo_next = {1'b0, dx_reg};
            end
            if (xhi_next < dx_reg)
            begin
                xhi_next = dx_reg;
            end
            if (ylo_next > {1'b0, dy_reg})
            begin
                ylo_next = {1'b0, dy_reg};
            end
            if (yhi_next < dy_reg)
            begin
                yhi_next = dy_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            xlo_reg       <= BOX_W'(FRAME_W);
            xhi_reg       <= '0;
            ylo_reg       <= BOX_W'(FRAME_H);
            yhi_reg       <= '0;
        end
        else if (adv)
        begin
            v1_reg        <= pop;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
            if (v4_reg)
            begin
                xlo_reg <= xlo_next;
                xhi_reg <= xhi_next;
                ylo_reg <= ylo_next;
                yhi_reg <= yhi_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            au_reg   <= cfg.coef_a * head.u;
            bv_reg   <= cfg.coef_b * head.v;
            cu_reg   <= cfg.coef_c * head.u;
            dv_reg   <= cfg.coef_d * head.v;
            lit1_reg <= head.lit;
            fs1_reg  <= head.fs;

            qx_reg   <= au_x + bv_x + e_x;
            qy_reg   <= cu_x + dv_x + f_x;
            lit2_reg <= lit1_reg;
            fs2_reg  <= fs1_reg;

            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            lit3_reg <= lit2_reg;
            fs3_reg  <= fs2_reg;

            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            lit4_reg <= lit3_reg;
            fs4_reg  <= fs3_reg;

            write_en_reg <= lit4_reg;
            dest_x_reg   <= dx_reg;
            dest_y_reg   <= dy_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign write_en  = write_en_reg;
    assign dest_x    = dest_x_reg;
    assign dest_y    = dest_y_reg;
    assign box_x_min = xlo_reg;
    assign box_x_max = xhi_reg;
    assign box_y_min = ylo_reg;
    assign box_y_max = yhi_reg;

endmodule

@@ hw/rtl/affine_pixel_remap_bbox.sv @@
// An accepted pixel is queued, then passes stages 1 to 4 and the output register.
// Throughput: one pixel per clock cycle when the output side does not stall; the
// four-entry queue and the five-stage transform pipeline set this rate.
// Reset (rst_n low, asynchronous) restores the identity transform with zero offsets,
// clears the bounding box to empty and discards every transaction in flight.
module affine_pixel_remap_bbox
    import apr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COORD_W-1:0] pixel_x,
    input  logic [COORD_W-1:0] pixel_y,
    input  logic               pixel_lit,
    input  logic               frame_start,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               write_en,
    output logic [COORD_W-1:0] dest_x,
    output logic [COORD_W-1:0] dest_y,
    output logic [BOX_W-1:0]   box_x_min,
    output logic [COORD_W-1:0] box_x_max,
    output logic [BOX_W-1:0]   box_y_min,
    output logic [COORD_W-1:0] box_y_max
);

    // Configuration registers. Each register sits at a word address; the
    // word index picks the register and the byte offset bits are ignored.
    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    logic                  cfg_write;
    logic [REG_IDX_W-1:0]  reg_idx;

    // Front-to-queue and queue-to-back connections.
    logic      push;
    entry_t    push_entry;
    logic      pop;
    entry_t    head;
    q_status_t q_status;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // A write replaces one register; the data is truncated to its width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                REG_COEF_A:  cfg_next.coef_a  = pwdata[COEF_W-1:0];
                REG_COEF_B:  cfg_next.coef_b  = pwdata[COEF_W-1:0];
                REG_COEF_C:  cfg_next.coef_c  = pwdata[COEF_W-1:0];
                REG_COEF_D:  cfg_next.coef_d  = pwdata[COEF_W-1:0];
                REG_TRANS_E: cfg_next.trans_e = pwdata[TRANS_W-1:0];
                REG_TRANS_F: cfg_next.trans_f = pwdata[TRANS_W-1:0];
                REG_SHIFT_X: cfg_next.shift_x = pwdata[SHIFT_W-1:0];
                REG_SHIFT_Y: cfg_next.shift_y = pwdata[SHIFT_W-1:0];
            endcase
        end
    end

    // Reads return the register sign-extended to the bus width.
    always_comb
    begin
        unique case (reg_idx)
            REG_COEF_A:  prdata = DATA_W'(cfg_reg.coef_a);
            REG_COEF_B:  prdata = DATA_W'(cfg_reg.coef_b);
            REG_COEF_C:  prdata = DATA_W'(cfg_reg.coef_c);
            REG_COEF_D:  prdata = DATA_W'(cfg_reg.coef_d);
            REG_TRANS_E: prdata = DATA_W'(cfg_reg.trans_e);
            REG_TRANS_F: prdata = DATA_W'(cfg_reg.trans_f);
            REG_SHIFT_X: prdata = DATA_W'(cfg_reg.shift_x);
            REG_SHIFT_Y: prdata = DATA_W'(cfg_reg.shift_y);
        endcase
    end

    // The identity matrix is 1.0 on the diagonal in Q8.16.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_a  <= COEF_W'(65536);
            cfg_reg.coef_b  <= '0;
            cfg_reg.coef_c  <= '0;
            cfg_reg.coef_d  <= COEF_W'(65536);
            cfg_reg.trans_e <= '0;
            cfg_reg.trans_f <= '0;
            cfg_reg.shift_x <= '0;
            cfg_reg.shift_y <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front offsets each accepted pixel, flips its row and queues it.
    apr_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_lit   (pixel_lit),
        .frame_start (frame_start),
        .shift_x     (cfg_reg.shift_x),
        .shift_y     (cfg_reg.shift_y),
        .q_status    (q_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    // The queue lets the input side keep taking transactions while the
    // output side holds a result.
    apr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    // The back runs the matrix multiply, rounding, range checks and the
    // bounding box, and holds each result in its output register.
    apr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .write_en  (write_en),
        .dest_x    (dest_x),
        .dest_y    (dest_y),
        .box_x_min (box_x_min),
        .box_x_max (box_x_max),
        .box_y_min (box_y_min),
        .box_y_max (box_y_max)
    );

`ifndef SYNTHESIS
    // An unlit pixel never carries destination coordinates.
    a_unlit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_en) |-> (dest_x == '0 && dest_y == '0))
        else $error("unlit pixel has nonzero destination");

    // The box is widened on both axes at once, so both are empty or neither is.
    a_box_axes: assert property (@(posedge clk) disable iff (!rst_n)
        (box_x_min == BOX_W'(FRAME_W)) == (box_y_min == BOX_W'(FRAME_H)))
        else $error("bounding box axes disagree on emptiness");

    // A nonempty box has its minimum no larger than its maximum.
    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        (box_x_min != BOX_W'(FRAME_W))
            |-> (box_x_min <= {1'b0, box_x_max} && box_y_min <= {1'b0, box_y_max}))
        else $error("bounding box minimum exceeds maximum");
`endif

endmodule

@@ sim/affine_remap_checker.sv @@
module affine_remap_checker
    import apr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,

    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [COORD_W-1:0] pixel_x,
    input  logic [COORD_W-1:0] pixel_y,
    input  logic               pixel_lit,
    input  logic               frame_start,

    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               write_en,
    input  logic [COORD_W-1:0] dest_x,
    input  logic [COORD_W-1:0] dest_y,
    input  logic [BOX_W-1:0]   box_x_min,
    input  logic [COORD_W-1:0] box_x_max,
    input  logic [BOX_W-1:0]   box_y_min,
    input  logic [COORD_W-1:0] box_y_max,

    output int                 mismatches,
    output int                 pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               write_en;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [BOX_W-1:0]   x_min;
        logic [COORD_W-1:0] x_max;
        logic [BOX_W-1:0]   y_min;
        logic [COORD_W-1:0] y_max;
    } remap_result_t;

    cfg_t               xform;
    logic [BOX_W-1:0]   box_x_lo;
    logic [COORD_W-1:0] box_x_hi;
    logic [BOX_W-1:0]   box_y_lo;
    logic [COORD_W-1:0] box_y_hi;
    remap_result_t      dest_queue[$];
    int                 fail_count = 0;

    assign mismatches = fail_count;

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        if (got != want)
            flag_mismatch(what, got, want);
    endtask

    // Q24.16 to integer, ties go to the even neighbor.
    function automatic longint round_half_even(input longint q);
        longint     whole;
        logic [15:0] frac;
        whole = q >>> 16;
        frac  = q[15:0];
        if (frac > 16'h8000 || (frac == 16'h8000 && whole[0]))
            whole++;
        return whole;
    endfunction

    function automatic longint clip_axis(input longint t, input int limit);
        return (t >= 0 && t < limit) ? t : 0;
    endfunction

    task automatic clear_box();
        box_x_lo = BOX_W'(FRAME_W);
        box_x_hi = '0;
        box_y_lo = BOX_W'(FRAME_H);
        box_y_hi = '0;
    endtask

    task automatic remap_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                               input logic lit, input logic fs);
        longint        sx, sy, u, v, rx, ry, dx, dy;
        remap_result_t r;
        dx = 0;
        dy = 0;
        if (fs)
            clear_box();
        if (lit) begin
            sx = longint'($signed(xform.shift_x));
            sy = longint'($signed(xform.shift_y));
            u  = longint'(px) + sx;
            v  = longint'(FRAME_H) - (longint'(py) + sy) - 1;
            rx = longint'($signed(xform.coef_a)) * u + longint'($signed(xform.coef_b)) * v
                 + longint'($signed(xform.trans_e));
            ry = longint'($signed(xform.coef_c)) * u + longint'($signed(xform.coef_d)) * v
                 + longint'($signed(xform.trans_f));
            dx = clip_axis(round_half_even(rx) - sx, FRAME_W);
            dy = clip_axis(round_half_even(ry) - sy, FRAME_H);
            if (dx > 0 && dy > 0) begin
                if (box_x_lo > dx) box_x_lo = BOX_W'(dx);
                if (box_x_hi < dx) box_x_hi = COORD_W'(dx);
                if (box_y_lo > dy) box_y_lo = BOX_W'(dy);
                if (box_y_hi < dy) box_y_hi = COORD_W'(dy);
            end
        end
        r.write_en = lit;
        r.dest_x   = dx[COORD_W-1:0];
        r.dest_y   = dy[COORD_W-1:0];
        r.x_min    = box_x_lo;
        r.x_max    = box_x_hi;
        r.y_min    = box_y_lo;
        r.y_max    = box_y_hi;
        dest_queue.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n) begin
        remap_result_t want;
        if (!rst_n) begin
            xform.coef_a  = COEF_W'(65536);
            xform.coef_b  = '0;
            xform.coef_c  = '0;
            xform.coef_d  = COEF_W'(65536);
            xform.trans_e = '0;
            xform.trans_f = '0;
            xform.shift_x = '0;
            xform.shift_y = '0;
            clear_box();
            dest_queue.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[REG_IDX_W+1:2])
                    REG_COEF_A:  xform.coef_a  = pwdata[COEF_W-1:0];
                    REG_COEF_B:  xform.coef_b  = pwdata[COEF_W-1:0];
                    REG_COEF_C:  xform.coef_c  = pwdata[COEF_W-1:0];
                    REG_COEF_D:  xform.coef_d  = pwdata[COEF_W-1:0];
                    REG_TRANS_E: xform.trans_e = pwdata[TRANS_W-1:0];
                    REG_TRANS_F: xform.trans_f = pwdata[TRANS_W-1:0];
                    REG_SHIFT_X: xform.shift_x = pwdata[SHIFT_W-1:0];
                    REG_SHIFT_Y: xform.shift_y = pwdata[SHIFT_W-1:0];
                    default: ;
                endcase
            end

            // Results are checked before the new pixel is predicted, so an
            // empty queue cannot be satisfied by this edge's own input.
            if (out_valid && !out_stall) begin
                if (dest_queue.size() == 0) begin
                    flag_mismatch("result with nothing outstanding, dest_x", dest_x, 0);
                end else begin
                    want = dest_queue.pop_front();
                    check_field("write_en", write_en, want.write_en);
                    check_field("dest_x", dest_x, want.dest_x);
                    check_field("dest_y", dest_y, want.dest_y);
                    check_field("box_x_min", box_x_min, want.x_min);
                    check_field("box_x_max", box_x_max, want.x_max);
                    check_field("box_y_min", box_y_min, want.y_min);
                    check_field("box_y_max", box_y_max, want.y_max);
                end
            end

            if (in_valid && !in_stall)
                remap_pixel(pixel_x, pixel_y, pixel_lit, frame_start);

            pending <= dest_queue.size();
        end
    end

endmodule

@@ sim/tb.sv @@
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import apr_pkg::*;

    // Number of random configuration phases, and of random pixels sent in each.
    localparam int PHASES        = 10;
    localparam int PHASE_PIXELS  = 165;
    // Length of the long output hold-off used to back the block up.
    localparam int HOLD_CYCLES   = 100;
    // Idle cycles after the last result, a bit more than the pipeline depth.
    localparam int TAIL_CYCLES   = 12;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [COORD_W-1:0] pixel_x = '0;
    logic [COORD_W-1:0] pixel_y = '0;
    logic               pixel_lit = 1'b0;
    logic               frame_start = 1'b0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               write_en;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [BOX_W-1:0]   box_x_min;
    logic [COORD_W-1:0] box_x_max;
    logic [BOX_W-1:0]   box_y_min;
    logic [COORD_W-1:0] box_y_max;

    int                 mismatches;
    int                 pending;

    // When calm is set neither side inserts random idle cycles. When hold_req
    // is set the receiver runs its long hold-off, one unbroken stall.
    logic               calm = 1'b0;
    logic               hold_req = 1'b0;

    affine_pixel_remap_bbox u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_lit   (pixel_lit),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .write_en    (write_en),
        .dest_x      (dest_x),
        .dest_y      (dest_y),
        .box_x_min   (box_x_min),
        .box_x_max   (box_x_max),
        .box_y_min   (box_y_min),
        .box_y_max   (box_y_max)
    );

    // The checker sees both channels and the register port, keeps its own
    // copy of the transform and the bounding box, and counts mismatches.
    affine_remap_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_lit   (pixel_lit),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .write_en    (write_en),
        .dest_x      (dest_x),
        .dest_y      (dest_y),
        .box_x_min   (box_x_min),
        .box_x_max   (box_x_max),
        .box_y_min   (box_y_min),
        .box_y_max   (box_y_max),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Hard limit on the run. A correct run needs well under a tenth of this.
    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver side. It stalls at random with a 16 percent chance, not at
    // all while calm is set, and once runs a long hold-off that it counts
    // itself so that the internal queue fills and the input side stalls.
    initial
    begin
        int held;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && held < HOLD_CYCLES)
            begin
                out_stall <= 1'b1;
                held++;
            end
            else if (!calm && $urandom_range(99) < 16)
                out_stall <= 1'b1;
            else
                out_stall <= 1'b0;
        end
    end

    // Returns a random value of the given width, sign extended to 32 bits.
    function automatic int rand_signed(input int w);
        int r;
        r = int'($urandom);
        return (r <<< (32 - w)) >>> (32 - w);
    endfunction

    // One register write: a setup cycle, an access cycle, and the write lands
    // at the edge that ends the access cycle, where the port is released.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_transform(input int a, input int b, input int c, input int d,
                                 input int e, input int f, input int sx, input int sy);
        write_reg(REG_COEF_A, a);
        write_reg(REG_COEF_B, b);
        write_reg(REG_COEF_C, c);
        write_reg(REG_COEF_D, d);
        write_reg(REG_TRANS_E, e);
        write_reg(REG_TRANS_F, f);
        write_reg(REG_SHIFT_X, sx);
        write_reg(REG_SHIFT_Y, sy);
    endtask

    // Offers one pixel and returns once the transaction is accepted and any
    // idle gap is over. The caller is always positioned at a rising edge. If an
    // idle gap follows, valid is dropped at the acceptance edge; otherwise it
    // stays high and the next call just replaces the payload.
    task automatic send_pixel(input int px, input int py, input bit lit, input bit fs);
        in_valid    <= 1'b1;
        pixel_x     <= COORD_W'(px);
        pixel_y     <= COORD_W'(py);
        pixel_lit   <= lit;
        frame_start <= fs;
        do
            @(posedge clk);
        while (in_stall);
        if (!calm && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    task automatic send_random_pixel();
        send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(99) < 85, $urandom_range(99) < 4);
    endtask

    // Stops offering pixels and waits until every expected result is in, so
    // that the registers can be rewritten while the block is idle.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        int a, b, c, d, e, f, sx, sy;

        // Reset is applied once and released at an edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity transform from reset: corners, unlit pixels and frame
        // starts. A pixel on the left column or bottom row maps onto an axis
        // and must not widen the box.
        send_pixel(0, 0, 1'b1, 1'b1);
        send_pixel(1023, 1023, 1'b1, 1'b0);
        send_pixel(0, 1023, 1'b1, 1'b0);
        send_pixel(1023, 0, 1'b1, 1'b0);
        send_pixel(512, 300, 1'b1, 1'b0);
        send_pixel(5, 5, 1'b0, 1'b0);
        send_pixel(7, 9, 1'b0, 1'b1);
        send_pixel(100, 100, 1'b1, 1'b0);
        drain();

        // Scale by one half: odd inputs land exactly on a half and must round
        // to the even neighbor on both axes.
        set_transform(32768, 0, 0, 32768, 0, 0, 0, 0);
        send_pixel(1, 1022, 1'b1, 1'b1);
        send_pixel(3, 1020, 1'b1, 1'b0);
        send_pixel(5, 1018, 1'b1, 1'b0);
        send_pixel(2, 1021, 1'b1, 1'b0);
        drain();

        // Half-pixel translations, one negative: a tie below zero rounds to
        // an even negative value and that axis falls out of range.
        set_transform(65536, 0, 0, 65536, -98304, 32768, 0, 0);
        send_pixel(0, 1023, 1'b1, 1'b1);
        send_pixel(3, 1022, 1'b1, 1'b0);
        send_pixel(600, 400, 1'b1, 1'b0);
        drain();

        // Every register at one extreme, then all but coef_b at the other. Almost every
        // point leaves the frame on at least one axis.
        set_transform(8388607, -8388608, -8388608, 8388607,
                      2147483647, -2147483648, 4095, -4096);
        send_pixel(0, 0, 1'b1, 1'b1);
        send_pixel(1023, 1023, 1'b1, 1'b0);
        send_pixel(1023, 0, 1'b1, 1'b0);
        drain();
        set_transform(-8388608, -8388608, 8388607, -8388608,
                      -2147483648, 2147483647, -4096, 4095);
        send_pixel(0, 0, 1'b1, 1'b0);
        send_pixel(1023, 1023, 1'b1, 1'b0);
        send_pixel(0, 1023, 1'b1, 1'b1);
        send_pixel(511, 512, 1'b0, 1'b0);
        drain();

        // Random phases. Even phases use mild transforms near the identity so
        // most points stay inside the frame and the box keeps moving; every
        // fourth phase snaps coefficients and translations to half steps so
        // that ties are frequent. Odd phases use the full register ranges.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase % 2 == 0)
            begin
                a  = int'($urandom_range(0, 157286)) - 78643;
                b  = int'($urandom_range(0, 65536)) - 32768;
                c  = int'($urandom_range(0, 65536)) - 32768;
                d  = int'($urandom_range(0, 157286)) - 78643;
                e  = rand_signed(26);
                f  = rand_signed(26);
                sx = int'($urandom_range(0, 600)) - 300;
                sy = int'($urandom_range(0, 600)) - 300;
                if (phase % 4 == 0)
                begin
                    a = a & ~32'h7FFF;
                    b = b & ~32'h7FFF;
                    c = c & ~32'h7FFF;
                    d = d & ~32'h7FFF;
                    e = e & ~32'h7FFF;
                    f = f & ~32'h7FFF;
                end
            end
            else
            begin
                a  = rand_signed(COEF_W);
                b  = rand_signed(COEF_W);
                c  = rand_signed(COEF_W);
                d  = rand_signed(COEF_W);
                e  = rand_signed(TRANS_W);
                f  = rand_signed(TRANS_W);
                sx = rand_signed(SHIFT_W);
                sy = rand_signed(SHIFT_W);
            end
            set_transform(a, b, c, d, e, f, sx, sy);

            // One phase runs with no idling on either side at all.
            calm <= (phase == 3);
            // In another the receiver holds off for a long stretch while the
            // sender keeps offering pixels, so the block backs up.
            hold_req <= (phase == 6);
            @(posedge clk);

            for (int n = 0; n < PHASE_PIXELS; n++)
                send_random_pixel();
            drain();
            calm     <= 1'b0;
            hold_req <= 1'b0;
        end

        // Let the pipeline settle past its latency before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
